// ===== rtl/core/multi_flow_stride_prefetcher_assert.svh =====
// Assertion macros shared by the prefetcher RTL.
// No dependencies; every user is expected to have clk_i and rst_ni in scope.
`ifndef MULTI_FLOW_STRIDE_PREFETCHER_ASSERT_SVH
`define MULTI_FLOW_STRIDE_PREFETCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MFSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mfsp_pkg.sv =====
// Shared constants, types and register indexes of the multi-flow stride prefetcher.
// No dependencies.
package mfsp_pkg;

  // Sizing
  localparam int FLOWS        = 16;
  localparam int CORES        = 4;
  localparam int ADDR_BITS    = 48;
  localparam int MAX_PREFETCH = 16;
  localparam int PAGE_BITS    = 12;

  localparam int FLOW_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int NF_W   = $clog2(FLOWS + 1);
  localparam int TBL_W  = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int CNT_W  = $clog2(MAX_PREFETCH + 2);
  localparam int DIST_W = PAGE_BITS + 1;

  // Register file port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FLOW_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PER_CORE       = 3'd3;

  // Search distance bound: one page
  localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(1 << PAGE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  // Search token that walks down the cell chain
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] cur;
    logic [TBL_W-1:0]     tbl;
    logic [FLOW_W-1:0]    victim;
    logic [NF_W-1:0]      nf;
    logic                 hit;
    logic [DIST_W-1:0]    best_d;
    logic [FLOW_W-1:0]    best_idx;
    logic [ADDR_BITS-1:0] best_old;
    logic [ADDR_BITS-1:0] vic_old;
  } tok_t;

  // Entry update broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [TBL_W-1:0]     tbl;
    logic [FLOW_W-1:0]    idx;
    logic [ADDR_BITS-1:0] data;
  } wr_t;

  // Emitter command
  typedef struct packed {
    logic                 start;
    logic [ADDR_BITS-1:0] cur;
    logic [ADDR_BITS-1:0] stride;
    logic [CNT_W-1:0]     count;
    logic                 page_en;
  } emit_cmd_t;

endpackage

// ===== rtl/core/mfsp_cell.sv =====
// One flow cell: holds this flow's last address for every core table and
// refines the search token on its way down the chain. Depends on mfsp_pkg.
module mfsp_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mfsp_pkg::FLOW_W-1:0]   idx_i,
  input  mfsp_pkg::tok_t                tok_i,
  input  mfsp_pkg::wr_t                 wr_i,
  output mfsp_pkg::tok_t                tok_o
);

  logic [mfsp_pkg::ADDR_BITS-1:0] entry_q [mfsp_pkg::CORES];
  logic [mfsp_pkg::ADDR_BITS-1:0] entry;
  logic [mfsp_pkg::ADDR_BITS-1:0] diff;
  logic [mfsp_pkg::DIST_W-1:0]    abs_d;
  logic                           near;
  logic                           active;
  mfsp_pkg::tok_t                 tok_d, tok_q;

  // Distance check: |diff| < page size only when the upper bits are pure sign
  always_comb begin
    logic hi_zero, hi_ones;
    entry   = entry_q[tok_i.tbl];
    diff    = tok_i.cur - entry;
    hi_zero = (diff[mfsp_pkg::ADDR_BITS-1:mfsp_pkg::PAGE_BITS] == '0);
    hi_ones = (&diff[mfsp_pkg::ADDR_BITS-1:mfsp_pkg::PAGE_BITS]);
    near    = hi_zero || (hi_ones && (diff[mfsp_pkg::PAGE_BITS-1:0] != '0));
    if (hi_zero) begin
      abs_d = {1'b0, diff[mfsp_pkg::PAGE_BITS-1:0]};
    end else begin
      abs_d = '0 - diff[mfsp_pkg::DIST_W-1:0];
    end
    active = (mfsp_pkg::NF_W'(idx_i) < tok_i.nf);
  end

  // Token update: strict compare keeps the first closest flow
  always_comb begin
    tok_d = tok_i;
    if (active && near && (abs_d < tok_i.best_d)) begin
      tok_d.hit      = 1'b1;
      tok_d.best_d   = abs_d;
      tok_d.best_idx = idx_i;
      tok_d.best_old = entry;
    end
    if (tok_i.victim == idx_i) begin
      tok_d.vic_old = entry;
    end
  end

  // Token stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Flow storage, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mfsp_pkg::CORES; c++) begin
        entry_q[c] <= '0;
      end
    end else if (wr_i.en && (wr_i.idx == idx_i)) begin
      entry_q[wr_i.tbl] <= wr_i.data;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/core/mfsp_emit.sv =====
// Prefetch address generator: steps current + k*stride by repeated addition,
// filters by page and holds one result back to mark the last. Depends on mfsp_pkg.
module mfsp_emit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mfsp_pkg::emit_cmd_t            cmd_i,
  output logic                           active_o,
  output logic                           done_o,
  output logic                           strobe_o,
  output logic [mfsp_pkg::ADDR_BITS-1:0] addr_o,
  output logic                           last_o
);

  localparam int PG_W = mfsp_pkg::ADDR_BITS - mfsp_pkg::PAGE_BITS;

  logic                           active_q, pend_vld_q, out_vld_q, out_last_q, page_en_q;
  logic [mfsp_pkg::CNT_W-1:0]     k_q, count_q;
  logic [mfsp_pkg::ADDR_BITS-1:0] acc_q, stride_q, pend_q, out_addr_q;
  logic [PG_W-1:0]                page_q;
  logic                           in_range, keep, finish, emit_mid, emit_end;

  always_comb begin
    in_range = (k_q <= count_q);
    keep     = !page_en_q || (acc_q[mfsp_pkg::ADDR_BITS-1:mfsp_pkg::PAGE_BITS] == page_q);
    finish   = active_q && !in_range;
    emit_mid = active_q && in_range && keep && pend_vld_q;
    emit_end = finish && pend_vld_q;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      k_q        <= '0;
    end else begin
      out_vld_q <= emit_mid || emit_end;
      if (cmd_i.start) begin
        active_q   <= 1'b1;
        pend_vld_q <= 1'b0;
        k_q        <= mfsp_pkg::CNT_W'(1);
      end else if (active_q) begin
        if (in_range) begin
          k_q <= k_q + 1'b1;
          if (keep) begin
            pend_vld_q <= 1'b1;
          end
        end else begin
          active_q   <= 1'b0;
          pend_vld_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    out_addr_q <= pend_q;
    out_last_q <= emit_end;
    if (cmd_i.start) begin
      acc_q     <= cmd_i.cur + cmd_i.stride;
      stride_q  <= cmd_i.stride;
      count_q   <= cmd_i.count;
      page_en_q <= cmd_i.page_en;
      page_q    <= cmd_i.cur[mfsp_pkg::ADDR_BITS-1:mfsp_pkg::PAGE_BITS];
    end else if (active_q && in_range) begin
      acc_q <= acc_q + stride_q;
      if (keep) begin
        pend_q <= acc_q;
      end
    end
  end

  assign active_o = active_q;
  assign done_o   = finish;
  assign strobe_o = out_vld_q;
  assign addr_o   = out_addr_q;
  assign last_o   = out_last_q;

endmodule

// ===== rtl/core/multi_flow_stride_prefetcher.sv =====
// Multi-flow stride prefetcher top level: config registers, control and the cell chain.
// Depends on mfsp_pkg, mfsp_cell, mfsp_emit and multi_flow_stride_prefetcher_assert.svh.
//
// A demand address is taken when start_i is high and busy_o low. It then walks a
// chain of FLOWS flow cells, one cell per cycle, so the search visits all FLOWS cells
// whatever flow_count is. The chosen flow is updated and, for a nonzero stride,
// the generator adds the stride once per cycle for prefetch_count steps.
// An access stays busy through the search alone when the stride or prefetch_count is
// zero and through the search and all generator steps otherwise (prefetch_count
// saturated at MAX_PREFETCH), even when the page limit drops every address; the next
// access can be taken in the first cycle that busy_o is low. Results come one per
// strobe on result_strobe_o, each lasting one cycle; the receiver cannot stall them,
// and the final result of an access shows in the first cycle that busy_o is low.
// Config writes are always ready and must only be issued while the block is idle.

`include "multi_flow_stride_prefetcher_assert.svh"

module multi_flow_stride_prefetcher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Command channel
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [47:0]                      access_address_i,
  input  logic [1:0]                       core_offset_i,
  // Results
  output logic                             result_strobe_o,
  output logic [47:0]                      target_addr_o,
  output logic                             last_o,
  // Register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mfsp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfsp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  mfsp_pkg::state_e               state_q, state_d;
  logic [4:0]                     flow_count_q, prefetch_count_q;
  logic                           page_limit_q, per_core_q;
  logic [mfsp_pkg::FLOW_W-1:0]    victim_q, victim_d, victim_sel;
  logic [mfsp_pkg::NF_W-1:0]      nf, vic_inc;
  logic [mfsp_pkg::CNT_W-1:0]     np;
  logic                           accept;
  mfsp_pkg::tok_t                 chain [mfsp_pkg::FLOWS+1];
  mfsp_pkg::tok_t                 tail;
  mfsp_pkg::wr_t                  wr;
  mfsp_pkg::emit_cmd_t            cmd;
  logic [mfsp_pkg::ADDR_BITS-1:0] old_addr, stride;
  logic                           emit_active, emit_done;
  logic [mfsp_pkg::ADDR_BITS-1:0] emit_addr;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != mfsp_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_count_q     <= 5'd4;
      prefetch_count_q <= 5'd2;
      page_limit_q     <= 1'b1;
      per_core_q       <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mfsp_pkg::REG_FLOW_COUNT:     flow_count_q     <= cfg_data_i;
        mfsp_pkg::REG_PREFETCH_COUNT: prefetch_count_q <= cfg_data_i;
        mfsp_pkg::REG_PAGE_LIMIT:     page_limit_q     <= cfg_data_i[0];
        mfsp_pkg::REG_PER_CORE:       per_core_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturated counts and round-robin victim
  always_comb begin
    if (flow_count_q == '0) begin
      nf = mfsp_pkg::NF_W'(1);
    end else if (32'(flow_count_q) > mfsp_pkg::FLOWS) begin
      nf = mfsp_pkg::NF_W'(mfsp_pkg::FLOWS);
    end else begin
      nf = mfsp_pkg::NF_W'(flow_count_q);
    end
    if (32'(prefetch_count_q) > mfsp_pkg::MAX_PREFETCH) begin
      np = mfsp_pkg::CNT_W'(mfsp_pkg::MAX_PREFETCH);
    end else begin
      np = mfsp_pkg::CNT_W'(prefetch_count_q);
    end
    victim_sel = (mfsp_pkg::NF_W'(victim_q) >= nf) ? '0 : victim_q;
    vic_inc    = mfsp_pkg::NF_W'(victim_sel) + 1'b1;
    victim_d   = (vic_inc == nf) ? '0 : mfsp_pkg::FLOW_W'(vic_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      victim_q <= '0;
    end else if (accept) begin
      victim_q <= victim_d;
    end
  end

  // Token launched into the first cell
  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = accept;
    chain[0].cur      = access_address_i;
    chain[0].tbl      = per_core_q ?
                        mfsp_pkg::TBL_W'(32'(core_offset_i) % mfsp_pkg::CORES) : '0;
    chain[0].victim   = victim_sel;
    chain[0].nf       = nf;
    chain[0].best_d   = mfsp_pkg::DIST_LIMIT;
  end

  // Cell chain
  for (genvar g = 0; g < mfsp_pkg::FLOWS; g++) begin : g_cell
    mfsp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (mfsp_pkg::FLOW_W'(g)),
      .tok_i  (chain[g]),
      .wr_i   (wr),
      .tok_o  (chain[g+1])
    );
  end

  // Resolve the chosen flow at the chain end and write the access back
  always_comb begin
    tail          = chain[mfsp_pkg::FLOWS];
    old_addr      = tail.hit ? tail.best_old : tail.vic_old;
    stride        = tail.cur - old_addr;
    wr.en         = tail.valid;
    wr.tbl        = tail.tbl;
    wr.idx        = tail.hit ? tail.best_idx : tail.victim;
    wr.data       = tail.cur;
    cmd.start     = tail.valid && (stride != '0) && (np != '0);
    cmd.cur       = tail.cur;
    cmd.stride    = stride;
    cmd.count     = np;
    cmd.page_en   = page_limit_q;
  end

  mfsp_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .active_o (emit_active),
    .done_o   (emit_done),
    .strobe_o (result_strobe_o),
    .addr_o   (emit_addr),
    .last_o   (last_o)
  );

  assign target_addr_o = emit_addr;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfsp_pkg::ST_IDLE: begin
        if (accept) state_d = mfsp_pkg::ST_SEARCH;
      end
      mfsp_pkg::ST_SEARCH: begin
        if (tail.valid) begin
          state_d = cmd.start ? mfsp_pkg::ST_EMIT : mfsp_pkg::ST_IDLE;
        end
      end
      mfsp_pkg::ST_EMIT: begin
        if (emit_done) state_d = mfsp_pkg::ST_IDLE;
      end
      default: state_d = mfsp_pkg::ST_IDLE;
    endcase
  end

  // Checks
  `MFSP_ASSERT_NEXT(a_accept_busy, accept, busy_o, "accepted access did not raise busy")
  `MFSP_ASSERT_NOW(a_tail_in_search, tail.valid, state_q == mfsp_pkg::ST_SEARCH, "search token left the chain outside search")
  `MFSP_ASSERT_NOW(a_emit_in_state, emit_active, state_q == mfsp_pkg::ST_EMIT, "generator running outside emit state")
  `MFSP_ASSERT_NOW(a_strobe_after_emit, result_strobe_o, $past(state_q) == mfsp_pkg::ST_EMIT, "result beat without a preceding emit cycle")

endmodule
